// ===== design/qlsf_pkg.sv =====
// shared types, constants and solve microprogram for the quadratic fit unit
package qlsf_pkg;

    localparam int W              = 128;
    localparam int BW             = 64;
    localparam int DIG            = 8;
    localparam int FIELD_W        = 12;
    localparam int VAL_W          = 64;
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_COORD_BITS = 12;
    localparam int IN_FRAC        = 2;
    localparam int OUT_FRAC       = 32;
    localparam int NPROG          = 24;
    localparam int STEP_W         = 5;
    localparam int NVR            = 9;
    localparam int VR_IW          = 4;
    localparam int SH_W           = 6;
    localparam int DIV_IW         = $clog2(W + (1 << SH_W));

    // accumulation product steps
    localparam logic [2:0] ACC_X2  = 3'd0;
    localparam logic [2:0] ACC_X3  = 3'd1;
    localparam logic [2:0] ACC_X4  = 3'd2;
    localparam logic [2:0] ACC_XY  = 3'd3;
    localparam logic [2:0] ACC_X2Y = 3'd4;

    // coefficient indexes
    localparam logic [1:0] COEF_C = 2'd0;
    localparam logic [1:0] COEF_A = 2'd2;

    localparam logic [BW-1:0] MAX_VAL = {1'b0, {(BW-1){1'b1}}};
    localparam logic [BW-1:0] MIN_VAL = {1'b1, {(BW-1){1'b0}}};

    typedef enum logic [3:0] {
        SRC_M00 = 4'd0, SRC_M01 = 4'd1, SRC_M02 = 4'd2, SRC_M12 = 4'd3,
        SRC_M22 = 4'd4, SRC_T0  = 4'd5, SRC_T1  = 4'd6, SRC_T2  = 4'd7,
        SRC_A00 = 4'd8, SRC_A01 = 4'd9, SRC_A02 = 4'd10, SRC_A11 = 4'd11,
        SRC_A12 = 4'd12, SRC_A22 = 4'd13
    } t_src;

    typedef enum logic [3:0] {
        DST_A00 = 4'd0, DST_A01 = 4'd1, DST_A02 = 4'd2, DST_A11 = 4'd3,
        DST_A12 = 4'd4, DST_A22 = 4'd5, DST_N0  = 4'd6, DST_N1  = 4'd7,
        DST_N2  = 4'd8, DST_DEN = 4'd9
    } t_dst;

    typedef struct packed {
        t_src a_src;
        t_src b_src;
        logic clr;
        logic sub;
        logic wr;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } t_mul_ctl;

    function automatic t_uop mk_uop(t_src a, t_src b, logic c, logic s, logic w, t_dst d);
        t_uop u;
        u.a_src = a;
        u.b_src = b;
        u.clr   = c;
        u.sub   = s;
        u.wr    = w;
        u.dst   = d;
        return u;
    endfunction

    // cofactors, determinant and cramer numerators as multiply-accumulate steps
    function automatic t_uop prog_uop(logic [STEP_W-1:0] idx);
        t_uop u;
        u = mk_uop(SRC_M00, SRC_M00, 1'b0, 1'b0, 1'b0, DST_A00);
        case (idx)
            5'd0:  u = mk_uop(SRC_M02, SRC_M22, 1'b1, 1'b0, 1'b0, DST_A00);
            5'd1:  u = mk_uop(SRC_M12, SRC_M12, 1'b0, 1'b1, 1'b1, DST_A00);
            5'd2:  u = mk_uop(SRC_M02, SRC_M12, 1'b1, 1'b0, 1'b0, DST_A01);
            5'd3:  u = mk_uop(SRC_M01, SRC_M22, 1'b0, 1'b1, 1'b1, DST_A01);
            5'd4:  u = mk_uop(SRC_M01, SRC_M12, 1'b1, 1'b0, 1'b0, DST_A02);
            5'd5:  u = mk_uop(SRC_M02, SRC_M02, 1'b0, 1'b1, 1'b1, DST_A02);
            5'd6:  u = mk_uop(SRC_M00, SRC_M22, 1'b1, 1'b0, 1'b0, DST_A11);
            5'd7:  u = mk_uop(SRC_M02, SRC_M02, 1'b0, 1'b1, 1'b1, DST_A11);
            5'd8:  u = mk_uop(SRC_M01, SRC_M02, 1'b1, 1'b0, 1'b0, DST_A12);
            5'd9:  u = mk_uop(SRC_M00, SRC_M12, 1'b0, 1'b1, 1'b1, DST_A12);
            5'd10: u = mk_uop(SRC_M00, SRC_M02, 1'b1, 1'b0, 1'b0, DST_A22);
            5'd11: u = mk_uop(SRC_M01, SRC_M01, 1'b0, 1'b1, 1'b1, DST_A22);
            5'd12: u = mk_uop(SRC_A00, SRC_M00, 1'b1, 1'b0, 1'b0, DST_DEN);
            5'd13: u = mk_uop(SRC_A01, SRC_M01, 1'b0, 1'b0, 1'b0, DST_DEN);
            5'd14: u = mk_uop(SRC_A02, SRC_M02, 1'b0, 1'b0, 1'b1, DST_DEN);
            5'd15: u = mk_uop(SRC_A00, SRC_T0,  1'b1, 1'b0, 1'b0, DST_N0);
            5'd16: u = mk_uop(SRC_A01, SRC_T1,  1'b0, 1'b0, 1'b0, DST_N0);
            5'd17: u = mk_uop(SRC_A02, SRC_T2,  1'b0, 1'b0, 1'b1, DST_N0);
            5'd18: u = mk_uop(SRC_A01, SRC_T0,  1'b1, 1'b0, 1'b0, DST_N1);
            5'd19: u = mk_uop(SRC_A11, SRC_T1,  1'b0, 1'b0, 1'b0, DST_N1);
            5'd20: u = mk_uop(SRC_A12, SRC_T2,  1'b0, 1'b0, 1'b1, DST_N1);
            5'd21: u = mk_uop(SRC_A02, SRC_T0,  1'b1, 1'b0, 1'b0, DST_N2);
            5'd22: u = mk_uop(SRC_A12, SRC_T1,  1'b0, 1'b0, 1'b0, DST_N2);
            5'd23: u = mk_uop(SRC_A22, SRC_T2,  1'b0, 1'b0, 1'b1, DST_N2);
            default: u = mk_uop(SRC_M00, SRC_M00, 1'b0, 1'b0, 1'b0, DST_A00);
        endcase
        return u;
    endfunction

endpackage

// ===== design/qlsf_mul.sv =====
// shared multiply-accumulate unit, one multiplier digit per cycle, modulo 2^128
module qlsf_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qlsf_pkg::t_mul_ctl       i_ctl,
    input  logic [qlsf_pkg::W-1:0]   i_a,
    input  logic [qlsf_pkg::BW-1:0]  i_b,
    output logic                     o_done,
    output logic [qlsf_pkg::W-1:0]   o_acc
);

    logic                    r_busy;
    logic                    r_sub;
    logic [qlsf_pkg::W-1:0]  r_a;
    logic [qlsf_pkg::BW-1:0] r_b;
    logic [qlsf_pkg::W-1:0]  r_acc;
    logic [qlsf_pkg::W-1:0]  prod;
    logic [qlsf_pkg::W-1:0]  n_acc;

    // partial product of the low digit
    assign prod  = r_a * qlsf_pkg::W'(r_b[qlsf_pkg::DIG-1:0]);
    assign n_acc = r_sub ? (r_acc - prod) : (r_acc + prod);

    assign o_done = r_busy && (r_b == '0);
    assign o_acc  = r_acc;

    // digit loop, ends once the multiplier runs out of nonzero digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_a    <= i_a;
            r_b    <= i_b;
            r_sub  <= i_ctl.sub;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_a   <= r_a << qlsf_pkg::DIG;
                r_b   <= r_b >> qlsf_pkg::DIG;
            end
        end
    end

endmodule

// ===== design/qlsf_div.sv =====
// restoring divider: rounded, saturated Q31.32 quotient of num * 2^shift / den
module qlsf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qlsf_pkg::W-1:0]      i_num,
    input  logic [qlsf_pkg::W-1:0]      i_den,
    input  logic [qlsf_pkg::SH_W-1:0]   i_shift,
    output logic                        o_done,
    output logic [qlsf_pkg::BW-1:0]     o_value,
    output logic                        o_sat
);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_RND  = 3'b100
    } t_div_state;

    t_div_state                    r_state;
    logic [qlsf_pkg::DIV_IW-1:0]   r_i;
    logic [qlsf_pkg::SH_W-1:0]     r_shift;
    logic [qlsf_pkg::W-1:0]        r_n;
    logic [qlsf_pkg::W-1:0]        r_d;
    logic [qlsf_pkg::W-1:0]        r_r;
    logic [qlsf_pkg::BW-1:0]       r_q;
    logic                          r_ovf;
    logic                          r_neg;
    logic                          r_done;
    logic [qlsf_pkg::BW-1:0]       r_value;
    logic                          r_sat;

    logic                          take;
    logic [qlsf_pkg::W:0]          rs;
    logic [qlsf_pkg::W:0]          diff;
    logic                          ge;
    logic [qlsf_pkg::W-1:0]        n_r;
    logic [qlsf_pkg::W:0]          rs2;
    logic                          ge2;
    logic                          ovf2;
    logic [qlsf_pkg::BW-1:0]       q2;
    logic                          n_sat;
    logic [qlsf_pkg::BW-1:0]       n_value;

    // one quotient bit per cycle
    always_comb begin
        take = r_i >= qlsf_pkg::DIV_IW'(r_shift);
        rs   = {r_r, take & r_n[qlsf_pkg::W-1]};
        diff = rs - {1'b0, r_d};
        ge   = rs >= {1'b0, r_d};
        n_r  = ge ? diff[qlsf_pkg::W-1:0] : rs[qlsf_pkg::W-1:0];
    end

    // round half away from zero and clip to range
    always_comb begin
        rs2  = {r_r, 1'b0};
        ge2  = rs2 >= {1'b0, r_d};
        ovf2 = r_ovf | (ge2 & (&r_q));
        q2   = r_q + qlsf_pkg::BW'(ge2);
        if (r_neg) begin
            n_sat   = ovf2 | (q2 > qlsf_pkg::MIN_VAL);
            n_value = n_sat ? qlsf_pkg::MIN_VAL : (~q2 + 1'b1);
        end else begin
            n_sat   = ovf2 | q2[qlsf_pkg::BW-1];
            n_value = n_sat ? qlsf_pkg::MAX_VAL : q2;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_sat   = r_sat;

    // divider sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_num[qlsf_pkg::W-1] ? (~i_num + 1'b1) : i_num;
                        r_d     <= i_den[qlsf_pkg::W-1] ? (~i_den + 1'b1) : i_den;
                        r_neg   <= i_num[qlsf_pkg::W-1] ^ i_den[qlsf_pkg::W-1];
                        r_shift <= i_shift;
                        r_i     <= qlsf_pkg::DIV_IW'(qlsf_pkg::W - 1)
                                   + qlsf_pkg::DIV_IW'(i_shift);
                        r_r     <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    r_r   <= n_r;
                    r_q   <= {r_q[qlsf_pkg::BW-2:0], ge};
                    r_ovf <= r_ovf | r_q[qlsf_pkg::BW-1];
                    if (take) begin
                        r_n <= r_n << 1;
                    end
                    if (r_i == '0) begin
                        r_state <= DV_RND;
                    end else begin
                        r_i <= r_i - 1'b1;
                    end
                end
                DV_RND: begin
                    r_value <= n_value;
                    r_sat   <= n_sat;
                    r_done  <= 1'b1;
                    r_state <= DV_IDLE;
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

endmodule

// ===== design/quadratic_least_squares_fit_unit.sv =====
// quadratic least-squares fit: power-sum accumulation, exact 3x3 solve, three coefficients
// each point runs five products through the shared 128x8 multiplier.
// a solve runs 24 multiply-accumulate passes, then up to three bit-serial divisions,
// one per coefficient; each result waits for its taker.
// input stalls while summing a point, and from a last point until the last result is taken.
// synchronous active-low reset clears all sums, the count and the drop flag.
module quadratic_least_squares_fit_unit #(
    parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = qlsf_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [qlsf_pkg::FIELD_W-1:0]      i_x_coord,
    input  logic [qlsf_pkg::FIELD_W-1:0]      i_y_coord,
    input  logic                              i_last_point,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_coef_index,
    output logic signed [qlsf_pkg::VAL_W-1:0] o_coef_value,
    output logic                              o_singular,
    output logic                              o_dropped,
    output logic                              o_saturated,
    output logic                              o_last_coef
);

    localparam int C     = COORD_BITS;
    localparam int LG    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int S1    = C + LG;
    localparam int S2    = 2 * C + LG;
    localparam int S3    = 3 * C + LG;
    localparam int S4    = 4 * C + LG;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ACC   = 5'b00010,
        S_SOLVE = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                          r_state;
    logic [qlsf_pkg::STEP_W-1:0]     r_step;
    logic                            r_wait;
    logic                            r_last;
    logic [C-1:0]                    r_x;
    logic [C-1:0]                    r_y;
    logic [2*C-1:0]                  r_x2;
    logic [3*C-1:0]                  r_x3;
    logic [CNT_W-1:0]                r_cnt;
    logic [S1-1:0]                   r_sx;
    logic [S2-1:0]                   r_sx2;
    logic [S3-1:0]                   r_sx3;
    logic [S4-1:0]                   r_sx4;
    logic [S1-1:0]                   r_sy;
    logic [S2-1:0]                   r_sxy;
    logic [S3-1:0]                   r_sx2y;
    logic                            r_ovf;
    logic [qlsf_pkg::W-1:0]          r_den;
    logic [qlsf_pkg::W-1:0]          r_vr [qlsf_pkg::NVR];
    logic [1:0]                      r_k;
    logic                            r_ov;
    logic [1:0]                      r_oidx;
    logic [qlsf_pkg::VAL_W-1:0]      r_oval;
    logic                            r_osat;
    logic                            r_osing;
    logic                            r_odrop;
    logic                            r_olast;

    qlsf_pkg::t_uop                  u;
    qlsf_pkg::t_mul_ctl              mul_ctl;
    logic [qlsf_pkg::W-1:0]          mul_a;
    logic [qlsf_pkg::BW-1:0]         mul_b;
    logic                            mul_done;
    logic [qlsf_pkg::W-1:0]          mul_acc;
    logic [qlsf_pkg::VR_IW-1:0]      vr_idx;
    logic [qlsf_pkg::W-1:0]          vr_rd;
    logic [qlsf_pkg::W-1:0]          a_sum;
    logic [qlsf_pkg::BW-1:0]         b_sum;
    logic                            den_zero;
    logic                            div_start;
    logic                            div_done;
    logic [qlsf_pkg::BW-1:0]         div_val;
    logic                            div_sat;
    logic [qlsf_pkg::SH_W-1:0]       div_shift;

    assign u        = qlsf_pkg::prog_uop(r_step);
    assign den_zero = (r_den == '0);

    // one read port on the cofactor and numerator registers
    always_comb begin
        if (r_state == S_DIV) begin
            vr_idx = qlsf_pkg::VR_IW'(int'(qlsf_pkg::DST_N0) + int'(r_k));
        end else begin
            vr_idx = qlsf_pkg::VR_IW'(int'(u.a_src) - int'(qlsf_pkg::SRC_A00));
        end
        vr_rd = r_vr[vr_idx];
    end

    // normal matrix and right-hand side entries as operands
    always_comb begin
        case (u.a_src)
            qlsf_pkg::SRC_M00: a_sum = qlsf_pkg::W'(r_cnt);
            qlsf_pkg::SRC_M01: a_sum = qlsf_pkg::W'(r_sx);
            qlsf_pkg::SRC_M02: a_sum = qlsf_pkg::W'(r_sx2);
            qlsf_pkg::SRC_M12: a_sum = qlsf_pkg::W'(r_sx3);
            qlsf_pkg::SRC_M22: a_sum = qlsf_pkg::W'(r_sx4);
            qlsf_pkg::SRC_T0:  a_sum = qlsf_pkg::W'(r_sy);
            qlsf_pkg::SRC_T1:  a_sum = qlsf_pkg::W'(r_sxy);
            qlsf_pkg::SRC_T2:  a_sum = qlsf_pkg::W'(r_sx2y);
            default:           a_sum = vr_rd;
        endcase
        case (u.b_src)
            qlsf_pkg::SRC_M00: b_sum = qlsf_pkg::BW'(r_cnt);
            qlsf_pkg::SRC_M01: b_sum = qlsf_pkg::BW'(r_sx);
            qlsf_pkg::SRC_M02: b_sum = qlsf_pkg::BW'(r_sx2);
            qlsf_pkg::SRC_M12: b_sum = qlsf_pkg::BW'(r_sx3);
            qlsf_pkg::SRC_M22: b_sum = qlsf_pkg::BW'(r_sx4);
            qlsf_pkg::SRC_T0:  b_sum = qlsf_pkg::BW'(r_sy);
            qlsf_pkg::SRC_T1:  b_sum = qlsf_pkg::BW'(r_sxy);
            qlsf_pkg::SRC_T2:  b_sum = qlsf_pkg::BW'(r_sx2y);
            default:           b_sum = '0;
        endcase
    end

    // multiplier operand and control selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_ctl = '0;
        case (r_state)
            S_ACC: begin
                mul_ctl.start = !r_wait;
                mul_ctl.clr   = 1'b1;
                case (r_step[2:0])
                    qlsf_pkg::ACC_X2: begin
                        mul_a = qlsf_pkg::W'(r_x);
                        mul_b = qlsf_pkg::BW'(r_x);
                    end
                    qlsf_pkg::ACC_X3: begin
                        mul_a = qlsf_pkg::W'(r_x2);
                        mul_b = qlsf_pkg::BW'(r_x);
                    end
                    qlsf_pkg::ACC_X4: begin
                        mul_a = qlsf_pkg::W'(r_x3);
                        mul_b = qlsf_pkg::BW'(r_x);
                    end
                    qlsf_pkg::ACC_XY: begin
                        mul_a = qlsf_pkg::W'(r_y);
                        mul_b = qlsf_pkg::BW'(r_x);
                    end
                    default: begin
                        mul_a = qlsf_pkg::W'(r_x2);
                        mul_b = qlsf_pkg::BW'(r_y);
                    end
                endcase
            end
            S_SOLVE: begin
                mul_ctl.start = !r_wait;
                mul_ctl.clr   = u.clr;
                mul_ctl.sub   = u.sub;
                mul_a         = a_sum;
                mul_b         = b_sum;
            end
            default: mul_ctl = '0;
        endcase
    end

    assign div_start = (r_state == S_DIV) && !r_wait && !den_zero;
    assign div_shift = qlsf_pkg::SH_W'(qlsf_pkg::OUT_FRAC - qlsf_pkg::IN_FRAC
                                       + qlsf_pkg::IN_FRAC * int'(r_k));

    qlsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    qlsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (vr_rd),
        .i_den   (r_den),
        .i_shift (div_shift),
        .o_done  (div_done),
        .o_value (div_val),
        .o_sat   (div_sat)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_coef_index = r_oidx;
    assign o_coef_value = $signed(r_oval);
    assign o_singular   = r_osing;
    assign o_dropped    = r_odrop;
    assign o_saturated  = r_osat;
    assign o_last_coef  = r_olast;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_wait  <= 1'b0;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sx2   <= '0;
            r_sx3   <= '0;
            r_sx4   <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
            r_sx2y  <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                // take a request, or drop it when full
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x    <= i_x_coord[C-1:0];
                        r_y    <= i_y_coord[C-1:0];
                        r_last <= i_last_point;
                        r_step <= '0;
                        r_wait <= 1'b0;
                        if (r_cnt < CNT_W'(MAX_POINTS)) begin
                            r_state <= S_ACC;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_last_point) begin
                                r_state <= S_SOLVE;
                            end
                        end
                    end
                end
                // power products into the sums
                S_ACC: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        r_step <= r_step + 1'b1;
                        case (r_step[2:0])
                            qlsf_pkg::ACC_X2: begin
                                r_x2  <= mul_acc[2*C-1:0];
                                r_sx2 <= r_sx2 + S2'(mul_acc[2*C-1:0]);
                            end
                            qlsf_pkg::ACC_X3: begin
                                r_x3  <= mul_acc[3*C-1:0];
                                r_sx3 <= r_sx3 + S3'(mul_acc[3*C-1:0]);
                            end
                            qlsf_pkg::ACC_X4: begin
                                r_sx4 <= r_sx4 + S4'(mul_acc[4*C-1:0]);
                            end
                            qlsf_pkg::ACC_XY: begin
                                r_sxy <= r_sxy + S2'(mul_acc[2*C-1:0]);
                            end
                            default: begin
                                r_sx2y  <= r_sx2y + S3'(mul_acc[3*C-1:0]);
                                r_sx    <= r_sx + S1'(r_x);
                                r_sy    <= r_sy + S1'(r_y);
                                r_cnt   <= r_cnt + 1'b1;
                                r_step  <= '0;
                                r_state <= r_last ? S_SOLVE : S_IDLE;
                            end
                        endcase
                    end
                end
                // microprogram over the shared multiplier
                S_SOLVE: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        if (u.wr) begin
                            if (u.dst == qlsf_pkg::DST_DEN) begin
                                r_den <= mul_acc;
                            end else begin
                                r_vr[qlsf_pkg::VR_IW'(u.dst)] <= mul_acc;
                            end
                        end
                        if (r_step == qlsf_pkg::STEP_W'(qlsf_pkg::NPROG - 1)) begin
                            r_step  <= '0;
                            r_k     <= qlsf_pkg::COEF_C;
                            r_state <= S_DIV;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                // one coefficient per division, or a zero one without division when singular
                S_DIV: begin
                    if (den_zero || (r_wait && div_done)) begin
                        r_wait  <= 1'b0;
                        r_ov    <= 1'b1;
                        r_oidx  <= r_k;
                        r_oval  <= den_zero ? '0 : div_val;
                        r_osat  <= den_zero ? 1'b0 : div_sat;
                        r_osing <= den_zero;
                        r_odrop <= r_ovf;
                        r_olast <= (r_k == qlsf_pkg::COEF_A);
                        r_state <= S_OUT;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end
                end
                // hold the result until taken, then clear after the last one
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_ov <= 1'b0;
                        if (r_k == qlsf_pkg::COEF_A) begin
                            r_cnt   <= '0;
                            r_sx    <= '0;
                            r_sx2   <= '0;
                            r_sx3   <= '0;
                            r_sx4   <= '0;
                            r_sy    <= '0;
                            r_sxy   <= '0;
                            r_sx2y  <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/qlsf_checker.sv =====
// port-level checker for the quadratic fit unit and its bind
module qlsf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [qlsf_pkg::FIELD_W-1:0]      i_x_coord,
    input logic [qlsf_pkg::FIELD_W-1:0]      i_y_coord,
    input logic                              i_last_point,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [1:0]                        o_coef_index,
    input logic signed [qlsf_pkg::VAL_W-1:0] o_coef_value,
    input logic                              o_singular,
    input logic                              o_dropped,
    input logic                              o_saturated,
    input logic                              o_last_coef
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_coef_value)
                                       && $stable(o_coef_index))
        else $error("stalled result changed");

    // no new request while a result is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // singular system gives clean zero coefficients
    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> (o_coef_value == '0) && !o_saturated)
        else $error("singular result not zero");

    // last flag only on the quadratic term
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_coef == (o_coef_index == qlsf_pkg::COEF_A)))
        else $error("last flag on wrong coefficient");

    // a clipped value sits at a range limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            ($unsigned(o_coef_value) == qlsf_pkg::MAX_VAL)
            || ($unsigned(o_coef_value) == qlsf_pkg::MIN_VAL))
        else $error("saturated value off the limits");

endmodule

bind quadratic_least_squares_fit_unit qlsf_checker u_qlsf_checker (.*);

// ===== sim/tb_quadratic_least_squares_fit_unit.sv =====
// testbench for the quadratic least-squares fit unit: predicted coefficients checked per request
`timescale 1ns / 1ps

module tb_quadratic_least_squares_fit_unit;

    localparam int CAPACITY = qlsf_pkg::DEF_MAX_POINTS;

    typedef struct {
        logic [1:0]  index;
        logic [63:0] value;
        logic        singular;
        logic        dropped;
        logic        saturated;
        logic        last;
    } t_coef;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [qlsf_pkg::FIELD_W-1:0] x_coord;
    logic [qlsf_pkg::FIELD_W-1:0] y_coord;
    logic                         last_point;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   coef_index;
    logic signed [63:0]           coef_value;
    logic                         singular;
    logic                         dropped;
    logic                         saturated;
    logic                         last_coef;

    // running power sums of the fit in progress
    int          fit_count;
    logic [63:0] fit_sx, fit_sx2, fit_sx3, fit_sx4, fit_sy, fit_sxy, fit_sx2y;
    bit          fit_overflow;

    t_coef coef_queue[$];
    int    error_count;
    bit    idle_enable;

    quadratic_least_squares_fit_unit uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_x_coord    (x_coord),
        .i_y_coord    (y_coord),
        .i_last_point (last_point),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_coef_index (coef_index),
        .o_coef_value (coef_value),
        .o_singular   (singular),
        .o_dropped    (dropped),
        .o_saturated  (saturated),
        .o_last_coef  (last_coef)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run time limit
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // rounded, saturated quotient num * 2^sh / den in Q31.32
    function automatic logic [63:0] scaled_quotient(input logic [127:0] num,
                                                    input logic [127:0] den,
                                                    input int sh, output bit sat);
        logic [127:0] n_abs;
        logic [127:0] d_abs;
        logic [199:0] n_mag;
        logic [199:0] d_mag;
        logic [199:0] quo;
        logic [199:0] rem;
        bit           neg;
        neg   = num[127] ^ den[127];
        n_abs = num[127] ? -num : num;
        d_abs = den[127] ? -den : den;
        n_mag = 200'(n_abs);
        d_mag = 200'(d_abs);
        n_mag = n_mag << sh;
        quo   = n_mag / d_mag;
        rem   = n_mag % d_mag;
        if ((rem << 1) >= d_mag)
            quo = quo + 1;
        sat = 1'b0;
        if (neg) begin
            if (quo > 200'h8000000000000000) begin
                sat = 1'b1;
                return qlsf_pkg::MIN_VAL;
            end
            return 64'(-quo);
        end
        if (quo > 200'h7FFFFFFFFFFFFFFF) begin
            sat = 1'b1;
            return qlsf_pkg::MAX_VAL;
        end
        return quo[63:0];
    endfunction

    function automatic void clear_fit();
        fit_count = 0;
        fit_sx = 0; fit_sx2 = 0; fit_sx3 = 0; fit_sx4 = 0;
        fit_sy = 0; fit_sxy = 0; fit_sx2y = 0;
        fit_overflow = 1'b0;
    endfunction

    // accumulate one accepted point, solve on the last one
    function automatic void predict_point(input logic [11:0] xc, input logic [11:0] yc,
                                          input logic lp);
        logic [63:0]  x, y, x2;
        logic [127:0] m00, m01, m02, m12, m22, t0, t1, t2;
        logic [127:0] a00, a01, a02, a11, a12, a22, den;
        logic [127:0] num[3];
        bit           sing;
        bit           sat;
        t_coef        c;
        x = 64'(xc);
        y = 64'(yc);
        x2 = x * x;
        if (fit_count < CAPACITY) begin
            fit_count++;
            fit_sx   += x;
            fit_sx2  += x2;
            fit_sx3  += x2 * x;
            fit_sx4  += x2 * x2;
            fit_sy   += y;
            fit_sxy  += x * y;
            fit_sx2y += x2 * y;
        end else begin
            fit_overflow = 1'b1;
        end
        if (!lp)
            return;
        m00 = 128'(fit_count); m01 = 128'(fit_sx); m02 = 128'(fit_sx2);
        m12 = 128'(fit_sx3);   m22 = 128'(fit_sx4);
        t0 = 128'(fit_sy); t1 = 128'(fit_sxy); t2 = 128'(fit_sx2y);
        // cofactors of the symmetric normal matrix, all modulo 2^128
        a00 = m02 * m22 - m12 * m12;
        a01 = m02 * m12 - m01 * m22;
        a02 = m01 * m12 - m02 * m02;
        a11 = m00 * m22 - m02 * m02;
        a12 = m01 * m02 - m00 * m12;
        a22 = m00 * m02 - m01 * m01;
        den    = a00 * m00 + a01 * m01 + a02 * m02;
        num[0] = a00 * t0 + a01 * t1 + a02 * t2;
        num[1] = a01 * t0 + a11 * t1 + a12 * t2;
        num[2] = a02 * t0 + a12 * t1 + a22 * t2;
        sing = (den == 0);
        for (int k = 0; k < 3; k++) begin
            sat = 1'b0;
            c.value = 64'd0;
            if (!sing)
                c.value = scaled_quotient(num[k], den, qlsf_pkg::OUT_FRAC - qlsf_pkg::IN_FRAC
                                          + qlsf_pkg::IN_FRAC * k, sat);
            c.index     = 2'(k);
            c.singular  = sing;
            c.dropped   = fit_overflow;
            c.saturated = sat;
            c.last      = (2'(k) == qlsf_pkg::COEF_A);
            coef_queue  = {coef_queue, c};
        end
        clear_fit();
    endfunction

    // result side stall bursts
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        t_coef e;
        if (rst_n && out_valid && !out_stall) begin
            if (coef_queue.size() == 0) begin
                $error("unexpected coefficient index=%0d value=%h", coef_index, coef_value);
                error_count++;
            end else begin
                e = coef_queue.pop_front();
                if (coef_index !== e.index) begin
                    $error("coef_index expected %0d actual %0d", e.index, coef_index);
                    error_count++;
                end
                if (coef_value !== e.value) begin
                    $error("coef_value expected %h actual %h", e.value, coef_value);
                    error_count++;
                end
                if (singular !== e.singular) begin
                    $error("singular expected %0b actual %0b", e.singular, singular);
                    error_count++;
                end
                if (dropped !== e.dropped) begin
                    $error("dropped expected %0b actual %0b", e.dropped, dropped);
                    error_count++;
                end
                if (saturated !== e.saturated) begin
                    $error("saturated expected %0b actual %0b", e.saturated, saturated);
                    error_count++;
                end
                if (last_coef !== e.last) begin
                    $error("last_coef expected %0b actual %0b", e.last, last_coef);
                    error_count++;
                end
            end
        end
    end

    // send one point request, with an optional idle burst before it
    task automatic send_point(input logic [11:0] xc, input logic [11:0] yc, input logic lp);
        int n;
        @(negedge clk);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        x_coord    = xc;
        y_coord    = yc;
        last_point = lp;
        in_valid   = 1'b1;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
            @(negedge clk);
        end
        predict_point(xc, yc, lp);
    endtask

    // hold off until every pending coefficient is taken
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (coef_queue.size() != 0)
            @(posedge clk);
    endtask

    // random fit of n points, optionally clustered x
    task automatic send_random_fit(input int n, input bit clustered);
        logic [11:0] base;
        logic [11:0] xc;
        base = 12'($urandom_range(0, 4095 - 16));
        for (int i = 0; i < n; i++) begin
            xc = clustered ? base + 12'($urandom_range(0, 15)) : 12'($urandom);
            send_point(xc, 12'($urandom), i == n - 1);
        end
    endtask

    // exact parabolas and the coordinate extremes
    task automatic test_basic_fits();
        send_point(12'd0, 12'd4, 1'b0);
        send_point(12'd4, 12'd12, 1'b0);
        send_point(12'd8, 12'd36, 1'b1);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd2048, 12'd0, 1'b0);
        send_point(12'd1365, 12'd2730, 1'b1);
        drain_results();
    endtask

    // fewer than three distinct x values
    task automatic test_singular_fits();
        send_point(12'd100, 12'd7, 1'b1);
        send_point(12'd5, 12'd9, 1'b0);
        send_point(12'd6, 12'd9, 1'b1);
        send_point(12'd4095, 12'd1, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd0, 12'd2, 1'b0);
        send_point(12'd0, 12'd3, 1'b1);
        drain_results();
    endtask

    // steep fits near the top of the range clip the constant term
    task automatic test_saturation();
        send_point(12'd4093, 12'd0, 1'b0);
        send_point(12'd4094, 12'd4095, 1'b0);
        send_point(12'd4095, 12'd0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd4094, 12'd0, 1'b0);
        send_point(12'd4093, 12'd4095, 1'b1);
        drain_results();
    endtask

    // more points than the capacity, last one dropped as well
    task automatic test_capacity();
        send_random_fit(CAPACITY + 2, 1'b0);
        drain_results();
    endtask

    // random fits, mostly well-formed, some short or clustered
    task automatic test_random_fits(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 2);
                1:       len = $urandom_range(3, 24);
                default: len = $urandom_range(3, 8);
            endcase
            send_random_fit(len, $urandom_range(0, 3) == 0);
            sent += len;
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        x_coord     = '0;
        y_coord     = '0;
        last_point  = 1'b0;
        error_count = 0;
        idle_enable = 1'b1;
        clear_fit();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_fits();
        test_singular_fits();
        test_saturation();
        test_random_fits(90);
        drain_results();
        test_capacity();
        idle_enable = 1'b0;
        test_random_fits(40);

        drain_results();
        repeat (1000) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
